[hw/rtl/wsi_pkg.sv]
// Shared types and constants for the waypoint smootherstep interpolator.
// Field widths, fixed-point constants, function codes and register indexes.
// No dependencies.
package wsi_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int POS_WIDTH     = 24;

    localparam int IDX_W   = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W   = 7;
    localparam int RATE_W  = 21;
    localparam int GRIP_W  = 16;
    localparam int PHASE_W = 16;
    localparam int DT_W    = 16;
    localparam int FUNC_W  = 2;
    localparam int WPI_W   = 6;
    localparam int ACC_W   = RATE_W + 1;
    localparam int STEP_W  = ACC_W - PHASE_W;
    localparam int INNER_W = 20;

    localparam int IN_FIELDS_W  = WPI_W + 3 * POS_WIDTH + GRIP_W + DT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * POS_WIDTH + GRIP_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int MUL_A_W = (POS_WIDTH + 1 > RATE_W + 1) ? POS_WIDTH + 1 : RATE_W + 1;
    localparam int MUL_B_W = INNER_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [RATE_W-1:0]  RATE_MAX   = 21'd1310720;
    localparam logic [RATE_W-1:0]  RATE_RESET = 21'd32768;
    localparam logic [GRIP_W-1:0]  GRIP_IDLE  = 16'd32768;
    localparam logic [ACC_W-1:0]   BLEND_C10  = 22'd655360;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_RESTART = 2'd1,
        FUNC_SAMPLE  = 2'd2
    } func_t;

    localparam logic CFG_WAYPOINT_COUNT = 1'b0;
    localparam logic CFG_INV_SEG_TIME   = 1'b1;

    typedef struct packed {
        logic [GRIP_W-1:0]           grip;
        logic signed [POS_WIDTH-1:0] z;
        logic signed [POS_WIDTH-1:0] y;
        logic signed [POS_WIDTH-1:0] x;
    } wp_t;

endpackage

[hw/rtl/waypoint_smootherstep_interpolator_top.sv]
// Waypoint smootherstep interpolator, top level.
// Waypoint memory, phase/segment tracking and a shared multiplier; uses wsi_pkg.
//
// Waypoints live in a synchronous memory written by load beats. A restart
// beat rewinds to segment 0, phase 0. A sample beat advances the phase by
// delta_time * min(inv_seg_time, 20.0) and returns one result beat: a smootherstep
// blend of the two neighboring waypoints, or the last waypoint with done_res set (on an
// empty table, zero positions and the idle grip). Load and restart beats give no result.
// A sample on an empty table goes through accept and the output register. A sample that
// finds the trajectory finished goes through accept, the memory read and the output
// register, and one whose advance reaches the last waypoint adds the first product and
// the phase and segment update. A blended sample has the accept state, eight products
// that pass one at a time through the single shared multiplier, the phase and segment
// update, the weight capture, the grip add and the output register; the two waypoint
// reads overlap the products. A result blocked downstream holds the block in its output
// state. The result register lets the next beat be accepted while a result waits.
module waypoint_smootherstep_interpolator_top
    import wsi_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // wp_index, wp_x, wp_y, wp_z, wp_grip, delta_time, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pos_x, pos_y, pos_z, grip, done_res, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [RATE_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INC, ST_ADV, ST_UU, ST_T1, ST_T2, ST_S,
        ST_LX, ST_LY, ST_LZ, ST_LG, ST_LEND, ST_LAST, ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            wc_reg;
    logic [RATE_W-1:0]           ist_reg;
    logic [CNT_W-1:0]            seg_reg;
    logic [PHASE_W-1:0]          phase_reg;
    logic [CNT_W-1:0]            last_reg;
    logic [DT_W-1:0]             dt_reg;
    logic [INNER_W-1:0]          inner_reg;
    logic [PHASE_W-1:0]          s_reg;
    wp_t                         a_reg;
    wp_t                         b_reg;
    wp_t                         res_reg;
    logic                        done_reg;
    logic                        m_valid_reg;
    logic [OUT_DATA_W-1:0]       m_data_reg;
    logic signed [PROD_W-1:0]    mul_p_reg;

    wp_t                         mem [MAX_WAYPOINTS];
    wp_t                         rd_data_reg;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;
    wp_t                         wr_data;

    logic                        s_accept;
    logic [WPI_W-1:0]            in_idx;
    logic [DT_W-1:0]             in_dt;
    logic [CNT_W-1:0]            cnt_eff;
    logic [CNT_W-1:0]            last_w;
    logic [RATE_W-1:0]           rate_sat;
    logic [ACC_W-1:0]            acc;
    logic [STEP_W-1:0]           steps;
    logic [CNT_W-1:0]            rem;
    logic [CNT_W-1:0]            seg_adv;
    logic [2*PHASE_W-1:0]        uu;
    logic [2*PHASE_W+2:0]        six_uu;
    logic [ACC_W-1:0]            inner_w;
    logic [PHASE_W-1:0]          t_hi;
    logic [PHASE_W-1:0]          s_w;
    logic signed [PROD_W-1:0]    q_w;
    logic signed [POS_WIDTH:0]   dx, dy, dz;
    logic signed [GRIP_W:0]      dg;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign in_idx = s_axis_tdata[WPI_W-1:0];
    assign in_dt  = s_axis_tdata[WPI_W+3*POS_WIDTH+GRIP_W +: DT_W];

    assign wr_data.x    = s_axis_tdata[WPI_W +: POS_WIDTH];
    assign wr_data.y    = s_axis_tdata[WPI_W+POS_WIDTH +: POS_WIDTH];
    assign wr_data.z    = s_axis_tdata[WPI_W+2*POS_WIDTH +: POS_WIDTH];
    assign wr_data.grip = s_axis_tdata[WPI_W+3*POS_WIDTH +: GRIP_W];
    assign wr_en = s_accept && (s_axis_tuser == FUNC_LOAD) &&
                   (32'(in_idx) < MAX_WAYPOINTS);

    assign cnt_eff  = (32'(wc_reg) > MAX_WAYPOINTS) ? CNT_W'(MAX_WAYPOINTS) : wc_reg;
    assign last_w   = cnt_eff - CNT_W'(1);
    assign rate_sat = (ist_reg > RATE_MAX) ? RATE_MAX : ist_reg;

    // phase advance from the registered delta_time * rate product
    assign acc     = ACC_W'(phase_reg) + ACC_W'(mul_p_reg[PHASE_W +: RATE_W]);
    assign steps   = acc[ACC_W-1:PHASE_W];
    assign rem     = last_reg - seg_reg;
    assign seg_adv = (CNT_W'(steps) >= rem) ? last_reg : seg_reg + CNT_W'(steps);

    // inner = 10 - 15u + 6u^2 in Q.16
    assign uu      = mul_p_reg[2*PHASE_W-1:0];
    assign six_uu  = ((2*PHASE_W+3)'(uu) << 2) + ((2*PHASE_W+3)'(uu) << 1);
    assign inner_w = BLEND_C10 - ((ACC_W'(phase_reg) << 4) - ACC_W'(phase_reg))
                     + ACC_W'(six_uu[2*PHASE_W+2:PHASE_W]);
    assign t_hi    = mul_p_reg[2*PHASE_W-1:PHASE_W];
    assign s_w     = (mul_p_reg[PROD_W-1:2*PHASE_W] != '0) ? '1 : t_hi;
    assign q_w     = mul_p_reg >>> PHASE_W;

    assign dx = $signed({b_reg.x[POS_WIDTH-1], b_reg.x}) -
                $signed({a_reg.x[POS_WIDTH-1], a_reg.x});
    assign dy = $signed({b_reg.y[POS_WIDTH-1], b_reg.y}) -
                $signed({a_reg.y[POS_WIDTH-1], a_reg.y});
    assign dz = $signed({b_reg.z[POS_WIDTH-1], b_reg.z}) -
                $signed({a_reg.z[POS_WIDTH-1], a_reg.z});
    assign dg = $signed({1'b0, b_reg.grip}) - $signed({1'b0, a_reg.grip});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_INC: begin
                mul_a = $signed(MUL_A_W'(rate_sat));
                mul_b = $signed(MUL_B_W'(dt_reg));
            end
            ST_UU: begin
                mul_a = $signed(MUL_A_W'(phase_reg));
                mul_b = $signed(MUL_B_W'(phase_reg));
            end
            ST_T1: begin
                mul_a = $signed(MUL_A_W'(t_hi));
                mul_b = $signed(MUL_B_W'(phase_reg));
            end
            ST_T2: begin
                mul_a = $signed(MUL_A_W'(t_hi));
                mul_b = $signed(MUL_B_W'(inner_reg));
            end
            ST_LX: begin
                mul_a = MUL_A_W'(dx);
                mul_b = $signed(MUL_B_W'(s_reg));
            end
            ST_LY: begin
                mul_a = MUL_A_W'(dy);
                mul_b = $signed(MUL_B_W'(s_reg));
            end
            ST_LZ: begin
                mul_a = MUL_A_W'(dz);
                mul_b = $signed(MUL_B_W'(s_reg));
            end
            ST_LG: begin
                mul_a = MUL_A_W'(dg);
                mul_b = $signed(MUL_B_W'(s_reg));
            end
            default: ;
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_IDLE: rd_addr = IDX_W'(last_w);
            ST_ADV:  rd_addr = IDX_W'(seg_adv);
            ST_UU:   rd_addr = IDX_W'(seg_reg + CNT_W'(1));
            default: rd_addr = IDX_W'(seg_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[IDX_W'(in_idx)] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        mul_p_reg   <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wc_reg      <= '0;
            ist_reg     <= RATE_RESET;
            seg_reg     <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_WAYPOINT_COUNT: wc_reg  <= cfg_data[CNT_W-1:0];
                    CFG_INV_SEG_TIME:   ist_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_axis_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (s_axis_tuser)
                            FUNC_RESTART: begin
                                seg_reg   <= '0;
                                phase_reg <= '0;
                            end
                            FUNC_SAMPLE: begin
                                last_reg <= last_w;
                                dt_reg   <= in_dt;
                                if (cnt_eff == '0) begin
                                    res_reg.x    <= '0;
                                    res_reg.y    <= '0;
                                    res_reg.z    <= '0;
                                    res_reg.grip <= GRIP_IDLE;
                                    done_reg     <= 1'b1;
                                    state_reg    <= ST_OUT;
                                end else if (seg_reg >= last_w) begin
                                    state_reg <= ST_LAST;
                                end else begin
                                    state_reg <= ST_INC;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_INC: state_reg <= ST_ADV;
                ST_ADV: begin
                    phase_reg <= acc[PHASE_W-1:0];
                    seg_reg   <= seg_adv;
                    state_reg <= (seg_adv >= last_reg) ? ST_LAST : ST_UU;
                end
                ST_UU: begin
                    a_reg     <= rd_data_reg;
                    state_reg <= ST_T1;
                end
                ST_T1: begin
                    b_reg     <= rd_data_reg;
                    inner_reg <= inner_w[INNER_W-1:0];
                    state_reg <= ST_T2;
                end
                ST_T2: state_reg <= ST_S;
                ST_S: begin
                    s_reg     <= s_w;
                    state_reg <= ST_LX;
                end
                ST_LX: state_reg <= ST_LY;
                ST_LY: begin
                    res_reg.x <= a_reg.x + q_w[POS_WIDTH-1:0];
                    state_reg <= ST_LZ;
                end
                ST_LZ: begin
                    res_reg.y <= a_reg.y + q_w[POS_WIDTH-1:0];
                    state_reg <= ST_LG;
                end
                ST_LG: begin
                    res_reg.z <= a_reg.z + q_w[POS_WIDTH-1:0];
                    state_reg <= ST_LEND;
                end
                ST_LEND: begin
                    res_reg.grip <= a_reg.grip + q_w[GRIP_W-1:0];
                    done_reg     <= 1'b0;
                    state_reg    <= ST_OUT;
                end
                ST_LAST: begin
                    res_reg   <= rd_data_reg;
                    done_reg  <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg  <= OUT_DATA_W'({done_reg, res_reg.grip, res_reg.z,
                                                    res_reg.y, res_reg.x});
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[bench/waypoint_smootherstep_interpolator_top_tb.sv]
// Testbench for waypoint_smootherstep_interpolator_top: load, restart, sample and unused
// beats with random stalls on both streams, each result checked against a scoreboard model.
// Depends on wsi_pkg and the top-level RTL.

import wsi_pkg::*;

typedef struct {
    logic signed [POS_WIDTH-1:0] pos [3];
    logic [GRIP_W-1:0]           grip;
    logic                        done;
} traj_point_t;

class traj_scoreboard;
    localparam int GRIP_LSB = WPI_W + 3 * POS_WIDTH;
    localparam int DT_LSB   = GRIP_LSB + GRIP_W;

    longint            slot_pos [MAX_WAYPOINTS][3];
    longint            slot_grip [MAX_WAYPOINTS];
    int unsigned       segment_idx;
    int unsigned       phase_acc;
    logic [CNT_W-1:0]  wp_count;
    logic [RATE_W-1:0] seg_rate;
    traj_point_t       pending_q [$];
    int                errors;

    function new();
        for (int i = 0; i < MAX_WAYPOINTS; i++) begin
            slot_grip[i] = 0;
            for (int k = 0; k < 3; k++) slot_pos[i][k] = 0;
        end
        segment_idx = 0;
        phase_acc   = 0;
        wp_count    = '0;
        seg_rate    = RATE_RESET;
        errors      = 0;
    endfunction

    function logic [15:0] smooth_weight(logic [PHASE_W-1:0] u);
        longint unsigned uw, uu, t1, t2, inner, s;
        uw    = u;
        uu    = uw * uw;
        t1    = uu >> 16;
        t2    = (t1 * uw) >> 16;
        inner = ((64'd10 << 32) + 64'd6 * uu - ((64'd15 * uw) << 16)) >> 16;
        s     = (t2 * inner) >> 16;
        return (s > 64'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    // floor((b - a) * w / 2^16) added to a
    function longint ease_between(longint a, longint b, logic [15:0] w);
        longint wl;
        wl = w;
        return a + (((b - a) * wl) >>> 16);
    endfunction

    function traj_point_t slot_point(int unsigned i);
        traj_point_t e;
        for (int k = 0; k < 3; k++) e.pos[k] = slot_pos[i][k][POS_WIDTH-1:0];
        e.grip = slot_grip[i][GRIP_W-1:0];
        e.done = 1'b1;
        return e;
    endfunction

    function void note_config(logic idx, logic [RATE_W-1:0] val);
        if (idx == CFG_WAYPOINT_COUNT) wp_count = val[CNT_W-1:0];
        else seg_rate = val;
    endfunction

    function void note_beat(logic [FUNC_W-1:0] func, logic [IN_DATA_W-1:0] d);
        int unsigned                 eff, last, steps, idx;
        longint unsigned             acc, rate, dt;
        longint                      v;
        logic signed [POS_WIDTH-1:0] p;
        logic [15:0]                 w;
        traj_point_t                 e;
        case (func)
            FUNC_LOAD: begin
                idx = d[WPI_W-1:0];
                for (int k = 0; k < 3; k++) begin
                    p = d[WPI_W + k * POS_WIDTH +: POS_WIDTH];
                    slot_pos[idx][k] = p;
                end
                slot_grip[idx] = d[GRIP_LSB +: GRIP_W];
            end
            FUNC_RESTART: begin
                segment_idx = 0;
                phase_acc   = 0;
            end
            FUNC_SAMPLE: begin
                eff = (wp_count > MAX_WAYPOINTS) ? MAX_WAYPOINTS : wp_count;
                if (eff == 0) begin
                    for (int k = 0; k < 3; k++) e.pos[k] = '0;
                    e.grip = GRIP_IDLE;
                    e.done = 1'b1;
                end else begin
                    last = eff - 1;
                    if (eff != 1 && segment_idx < last) begin
                        rate        = (seg_rate > RATE_MAX) ? RATE_MAX : seg_rate;
                        dt          = d[DT_LSB +: DT_W];
                        acc         = phase_acc + ((dt * rate) >> 16);
                        steps       = acc >> 16;
                        phase_acc   = acc & 64'hFFFF;
                        if (steps >= last - segment_idx) segment_idx = last;
                        else segment_idx += steps;
                    end
                    if (segment_idx >= last) begin
                        e = slot_point(last);
                    end else begin
                        w = smooth_weight(phase_acc[15:0]);
                        for (int k = 0; k < 3; k++) begin
                            v = ease_between(slot_pos[segment_idx][k],
                                             slot_pos[segment_idx + 1][k], w);
                            e.pos[k] = v[POS_WIDTH-1:0];
                        end
                        v = ease_between(slot_grip[segment_idx], slot_grip[segment_idx + 1], w);
                        e.grip = v[GRIP_W-1:0];
                        e.done = 1'b0;
                    end
                end
                pending_q.push_back(e);
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
        traj_point_t e;
        if (pending_q.size() == 0) begin
            $display("%0t result with nothing pending: expected none actual %h", $time, d);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        for (int k = 0; k < 3; k++) begin
            if (d[k * POS_WIDTH +: POS_WIDTH] !== e.pos[k]) begin
                $display("%0t pos[%0d] mismatch: expected %h actual %h", $time, k, e.pos[k],
                         d[k * POS_WIDTH +: POS_WIDTH]);
                errors++;
            end
        end
        if (d[3 * POS_WIDTH +: GRIP_W] !== e.grip) begin
            $display("%0t grip mismatch: expected %h actual %h", $time, e.grip,
                     d[3 * POS_WIDTH +: GRIP_W]);
            errors++;
        end
        if (d[3 * POS_WIDTH + GRIP_W] !== e.done) begin
            $display("%0t done_res mismatch: expected %b actual %b", $time, e.done,
                     d[3 * POS_WIDTH + GRIP_W]);
            errors++;
        end
    endfunction
endclass

module waypoint_smootherstep_interpolator_top_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int RANDOM_ITEMS   = 700;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [POS_WIDTH-1:0] POS_MIN     = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic [POS_WIDTH-1:0] POS_MAX     = {1'b0, {(POS_WIDTH-1){1'b1}}};

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index     = 1'b0;
    logic [RATE_W-1:0]     cfg_data      = '0;

    traj_scoreboard sb;
    bit             slot_loaded [MAX_WAYPOINTS];
    int             send_idle_pct  = 0;
    int             recv_idle_pct  = 0;
    int             stalled_cycles = 0;
    int             beats_sent     = 0;

    waypoint_smootherstep_interpolator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (aresetn && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                        || (cfg_valid && cfg_ready))) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] pack_beat(logic [WPI_W-1:0] idx,
            logic [POS_WIDTH-1:0] x, logic [POS_WIDTH-1:0] y, logic [POS_WIDTH-1:0] z,
            logic [GRIP_W-1:0] g, logic [DT_W-1:0] dt);
        return {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, dt, g, z, y, x, idx};
    endfunction

    function automatic logic [POS_WIDTH-1:0] rand_pos();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return POS_MIN;
            1:       return POS_MAX;
            default: return r[POS_WIDTH-1:0];
        endcase
    endfunction

    function automatic logic [GRIP_W-1:0] rand_grip();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return r[GRIP_W-1:0];
        endcase
    endfunction

    // mostly short ticks so trajectories cross segments one at a time
    function automatic logic [DT_W-1:0] rand_dt();
        logic [31:0] r;
        int unsigned pick;
        pick = $urandom_range(99);
        r    = $urandom;
        if (pick < 5) return '0;
        if (pick < 10) return '1;
        if (pick < 70) return r[11:0];
        return r[DT_W-1:0];
    endfunction

    // called at a falling edge, returns at a falling edge with tvalid still high
    task automatic push_beat(logic [FUNC_W-1:0] func, logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_beat(func, data);
        if (func == FUNC_LOAD) slot_loaded[data[WPI_W-1:0]] = 1'b1;
        if (func != FUNC_UNUSED) beats_sent++;
        @(negedge aclk);
    endtask

    task automatic beat(logic [FUNC_W-1:0] func, logic [WPI_W-1:0] idx,
            logic [POS_WIDTH-1:0] x, logic [POS_WIDTH-1:0] y, logic [POS_WIDTH-1:0] z,
            logic [GRIP_W-1:0] g, logic [DT_W-1:0] dt);
        push_beat(func, pack_beat(idx, x, y, z, g, dt));
    endtask

    task automatic write_reg(logic idx, logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.note_config(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // drain all pending results, then let a trailing sample finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // every slot a sample may read must hold loaded data
    task automatic ensure_loaded(int unsigned eff);
        logic [31:0] i_v;
        for (int unsigned i = 0; i < eff; i++) begin
            i_v = i;
            if (!slot_loaded[i])
                beat(FUNC_LOAD, i_v[WPI_W-1:0], rand_pos(), rand_pos(), rand_pos(),
                     rand_grip(), rand_dt());
        end
    endtask

    task automatic random_beat();
        int unsigned       pick;
        logic [31:0]       r;
        logic [FUNC_W-1:0] func;
        pick = $urandom_range(99);
        r    = $urandom;
        if (pick < 70) func = FUNC_SAMPLE;
        else if (pick < 80) func = FUNC_RESTART;
        else if (pick < 95) func = FUNC_LOAD;
        else func = FUNC_UNUSED;
        beat(func, r[WPI_W-1:0], rand_pos(), rand_pos(), rand_pos(), rand_grip(), rand_dt());
    endtask

    task automatic random_phase();
        int unsigned       pick, cnt_v, rate_v, eff;
        logic [31:0]       r;
        logic [CNT_W-1:0]  cnt;
        pick = $urandom_range(99);
        if (pick < 8) cnt_v = 0;
        else if (pick < 16) cnt_v = 1;
        else if (pick < 24) cnt_v = 2;
        else if (pick < 32) cnt_v = MAX_WAYPOINTS;
        else if (pick < 38) cnt_v = $urandom_range(MAX_WAYPOINTS + 1, 127);
        else cnt_v = $urandom_range(3, 16);
        cnt = cnt_v[CNT_W-1:0];
        r   = $urandom;
        if ($urandom_range(3) == 0) write_reg(CFG_WAYPOINT_COUNT, {r[RATE_W-1:CNT_W], cnt});
        else write_reg(CFG_WAYPOINT_COUNT, {{(RATE_W-CNT_W){1'b0}}, cnt});

        pick = $urandom_range(99);
        if (pick < 10) rate_v = 0;
        else if (pick < 20) rate_v = RATE_MAX;
        else if (pick < 30) rate_v = $urandom_range(RATE_MAX + 1, (1 << RATE_W) - 1);
        else if (pick < 40) rate_v = $urandom_range(1, 4096);
        else rate_v = $urandom_range(1, 655360);
        write_reg(CFG_INV_SEG_TIME, rate_v[RATE_W-1:0]);

        eff = (cnt_v > MAX_WAYPOINTS) ? MAX_WAYPOINTS : cnt_v;
        ensure_loaded(eff);
        repeat ($urandom_range(25, 50)) random_beat();
        settle();
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 88;

        // empty table, unused code, restart, then extreme waypoints
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, '1);
        beat(FUNC_UNUSED, '1, POS_MAX, POS_MAX, POS_MAX, '1, '1);
        beat(FUNC_RESTART, '0, '0, '0, '0, '0, '0);
        beat(FUNC_LOAD, 6'd0, POS_MIN, POS_MAX, '0, '0, '1);
        beat(FUNC_LOAD, 6'd1, POS_MAX, POS_MIN, '1, '1, '0);
        beat(FUNC_LOAD, 6'd2, rand_pos(), rand_pos(), rand_pos(), rand_grip(), rand_dt());
        beat(FUNC_LOAD, 6'd3, rand_pos(), rand_pos(), rand_pos(), rand_grip(), rand_dt());
        beat(FUNC_LOAD, '1, POS_MAX, POS_MAX, POS_MAX, '1, '0);
        settle();

        // single waypoint
        write_reg(CFG_WAYPOINT_COUNT, 21'd1);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, '1);
        settle();

        // rate above the 20/s ceiling, walk to the end and stay there
        write_reg(CFG_WAYPOINT_COUNT, 21'd4);
        write_reg(CFG_INV_SEG_TIME, '1);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, '0);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, 16'h0800);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, 16'h0400);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, '1);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, 16'h0100);
        beat(FUNC_RESTART, '1, '1, '1, '1, '1, '1);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, 16'h1A00);
        settle();

        // segment left past the end by a lowered count
        write_reg(CFG_WAYPOINT_COUNT, 21'd2);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, 16'h0100);
        beat(FUNC_RESTART, '0, '0, '0, '0, '0, '0);
        settle();

        write_reg(CFG_INV_SEG_TIME, '0);
        beat(FUNC_SAMPLE, '0, '0, '0, '0, '0, '1);
        settle();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 88 : 0;
            recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 17 : 0;
            beats_sent    = 0;
            while (beats_sent < RANDOM_ITEMS / 3) random_phase();
        end

        settle();
        if (sb.errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wsi_pkg.sv
hw/rtl/waypoint_smootherstep_interpolator_top.sv
bench/waypoint_smootherstep_interpolator_top_tb.sv
